### sv/tcea_pkg.sv
`default_nettype none

package tcea_pkg;

    // opcodes
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_LD  = 3'd2;
    localparam logic [2:0] OP_ST  = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam logic [2:0] OP_JE  = 3'd5;
    localparam logic [2:0] OP_JMP = 3'd6;
    localparam logic [2:0] OP_BAD = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_START_PC     = 2'd0;
    localparam logic [1:0] CFG_HIT_LATENCY  = 2'd1;
    localparam logic [1:0] CFG_MISS_LATENCY = 2'd2;

    // reset values
    localparam logic [15:0] START_PC_RST     = 16'd0;
    localparam logic [7:0]  HIT_LATENCY_RST  = 8'd2;
    localparam logic [7:0]  MISS_LATENCY_RST = 8'd45;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // depth of the result buffer
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0]         reg_a;
        logic               a_is_reg;
        logic [2:0]         reg_b;
        logic               b_is_reg;
        logic signed [7:0]  immediate;
        logic [15:0]        jump_target;
    } cmd_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  cycles_spent;
        logic        access_hit;
        logic        equal_flag_out;
        logic [31:0] instr_total;
        logic [31:0] cycle_total;
        logic [31:0] hit_total;
        logic [31:0] ldst_total;
        logic        invalid_op;
    } res_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic        a_ok;   // first operand names an existing register
        logic        b_ok;   // second operand names an existing register
        logic        ra_ok;  // reg_a index in range, flag ignored
        logic        rb_ok;  // reg_b index in range, flag ignored
        logic [7:0]  imm;
        logic [15:0] target;
    } dec_t;

endpackage

`default_nettype wire

### sv/tcea_fifo.sv
`default_nettype none

module tcea_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_stall,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_stall,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_stall = (count_reg == CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold entries; no reset on payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/tcea_front.sv
`default_nettype none

module tcea_front #(
    parameter int NUM_REGS = 6
) (
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire tcea_pkg::cmd_t cmd,
    output logic               dec_valid,
    input  wire logic          dec_stall,
    output tcea_pkg::dec_t     dec
);

    logic ra_ok, rb_ok;

    // range-check register indexes against the register count
    assign ra_ok = ({1'b0, cmd.reg_a} < 4'(NUM_REGS));
    assign rb_ok = ({1'b0, cmd.reg_b} < 4'(NUM_REGS));

    // classify the word and pass handshake through to the queue
    always_comb
    begin
        dec.op     = cmd.op;
        dec.reg_a  = cmd.reg_a;
        dec.reg_b  = cmd.reg_b;
        dec.ra_ok  = ra_ok;
        dec.rb_ok  = rb_ok;
        dec.a_ok   = cmd.a_is_reg && ra_ok;
        dec.b_ok   = cmd.b_is_reg && rb_ok;
        dec.imm    = cmd.immediate;
        dec.target = cmd.jump_target;
    end

    assign dec_valid = cmd_valid;
    assign cmd_stall = dec_stall;

endmodule

`default_nettype wire

### sv/tcea_back.sv
`default_nettype none

module tcea_back #(
    parameter int NUM_REGS  = 6,
    parameter int MEM_BYTES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    input  wire logic           dec_valid,
    output logic                dec_stall,
    input  wire tcea_pkg::dec_t dec,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tcea_pkg::res_t      res
);

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    // architectural state
    logic [7:0]           rf_reg [NUM_REGS];
    logic [7:0]           rf_next [NUM_REGS];
    logic [7:0]           rf_eff [NUM_REGS];
    logic [15:0]          pc_reg, pc_next;
    logic                 eq_reg, eq_next;
    logic [31:0]          instr_reg, instr_next;
    logic [31:0]          cycle_reg, cycle_next;
    logic [31:0]          hit_reg, hit_next;
    logic [31:0]          ldst_reg, ldst_next;
    logic [7:0]           hit_lat_reg;
    logic [7:0]           miss_lat_reg;
    logic [MEM_BYTES-1:0] touched_reg, touched_next;

    // load write-back in the cycle after issue
    logic                 ld_pend_reg, ld_pend_next;
    logic [2:0]           ld_idx_reg;
    logic                 ld_hit_reg;
    logic [7:0]           mem_rdata_reg;
    logic [7:0]           ld_data;

    logic [7:0]           local_mem [MEM_BYTES];

    logic                 fire;
    logic [7:0]           val_a, val_b, addr_val, src, sum;
    logic                 is_ld, is_st, addr_ok, data_ok, go, hit;
    logic [AW-1:0]        addr;
    logic                 mem_we, mem_re;
    logic [7:0]           mem_wdata;
    logic [7:0]           cycles;
    logic [32:0]          cycle_sum;

    assign fire      = dec_valid && !res_stall;
    assign dec_stall = res_stall;
    assign res_valid = dec_valid;

    // forward a pending load into the register view
    assign ld_data = ld_hit_reg ? mem_rdata_reg : 8'h00;

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            rf_eff[i] = (ld_pend_reg && (ld_idx_reg == 3'(i))) ? ld_data : rf_reg[i];
        end
    end

    // read both operands
    always_comb
    begin
        val_a = 8'h00;
        val_b = 8'h00;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (dec.reg_a == 3'(i))
            begin
                val_a = rf_eff[i];
            end
            if (dec.reg_b == 3'(i))
            begin
                val_b = rf_eff[i];
            end
        end
    end

    // memory access qualification
    assign is_ld    = (dec.op == tcea_pkg::OP_LD);
    assign is_st    = (dec.op == tcea_pkg::OP_ST);
    assign addr_val = is_ld ? val_b : val_a;
    assign addr_ok  = is_ld ? dec.rb_ok : dec.ra_ok;
    assign data_ok  = is_ld ? dec.a_ok : dec.b_ok;
    assign go       = (is_ld || is_st) && addr_ok && data_ok && !addr_val[7]
                      && ({1'b0, addr_val} < 9'(MEM_BYTES));
    assign addr     = addr_val[AW-1:0];
    assign hit      = go && touched_reg[addr];
    assign src      = dec.b_ok ? val_b : dec.imm;
    assign sum      = val_a + src;

    // a load miss stores zero so that later hits read the reset value
    assign mem_we    = fire && go && (is_st || !hit);
    assign mem_re    = fire && go && is_ld;
    assign mem_wdata = is_st ? val_b : 8'h00;

    // execute one word
    always_comb
    begin
        rf_next      = rf_eff;
        pc_next      = pc_reg;
        eq_next      = eq_reg;
        instr_next   = instr_reg;
        cycle_next   = cycle_reg;
        hit_next     = hit_reg;
        ldst_next    = ldst_reg;
        touched_next = touched_reg;
        ld_pend_next = 1'b0;
        cycles       = 8'd0;
        cycle_sum    = 33'd0;

        if (fire && (dec.op != tcea_pkg::OP_BAD))
        begin
            instr_next = (instr_reg == tcea_pkg::CNT_MAX) ? instr_reg : instr_reg + 32'd1;
            pc_next    = pc_reg + 16'd1;
            cycles     = 8'd1;
            case (dec.op)
                tcea_pkg::OP_MOV:
                begin
                    for (int i = 0; i < NUM_REGS; i++)
                    begin
                        if (dec.a_ok && (dec.reg_a == 3'(i)))
                        begin
                            rf_next[i] = src;
                        end
                    end
                end
                tcea_pkg::OP_ADD:
                begin
                    for (int i = 0; i < NUM_REGS; i++)
                    begin
                        if (dec.a_ok && (dec.reg_a == 3'(i)))
                        begin
                            rf_next[i] = sum;
                        end
                    end
                end
                tcea_pkg::OP_LD, tcea_pkg::OP_ST:
                begin
                    ldst_next = (ldst_reg == tcea_pkg::CNT_MAX) ? ldst_reg : ldst_reg + 32'd1;
                    cycles    = 8'd0;
                    if (go)
                    begin
                        cycles        = hit ? hit_lat_reg : miss_lat_reg;
                        touched_next[addr] = 1'b1;
                        ld_pend_next  = is_ld;
                        if (hit && (hit_reg != tcea_pkg::CNT_MAX))
                        begin
                            hit_next = hit_reg + 32'd1;
                        end
                    end
                end
                tcea_pkg::OP_CMP:
                begin
                    if (dec.a_ok && dec.b_ok)
                    begin
                        eq_next = (val_a == val_b);
                    end
                end
                tcea_pkg::OP_JE:
                begin
                    if (eq_reg)
                    begin
                        pc_next = dec.target;
                        eq_next = 1'b0;
                    end
                end
                tcea_pkg::OP_JMP:
                begin
                    pc_next = dec.target;
                end
                default:
                begin
                    pc_next = pc_reg;
                end
            endcase
            cycle_sum  = {1'b0, cycle_reg} + 33'(cycles);
            cycle_next = cycle_sum[32] ? tcea_pkg::CNT_MAX : cycle_sum[31:0];
        end

        // a start_pc write also reloads the program counter
        if (cfg_we && (cfg_index == tcea_pkg::CFG_START_PC))
        begin
            pc_next = cfg_data;
        end
    end

    // assemble the result word
    always_comb
    begin
        res.next_pc        = pc_next;
        res.cycles_spent   = cycles;
        res.access_hit     = hit && (dec.op != tcea_pkg::OP_BAD);
        res.equal_flag_out = eq_next;
        res.instr_total    = instr_next;
        res.cycle_total    = cycle_next;
        res.hit_total      = hit_next;
        res.ldst_total     = ldst_next;
        res.invalid_op     = (dec.op == tcea_pkg::OP_BAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= 8'h00;
            end
            pc_reg       <= tcea_pkg::START_PC_RST;
            eq_reg       <= 1'b0;
            instr_reg    <= '0;
            cycle_reg    <= '0;
            hit_reg      <= '0;
            ldst_reg     <= '0;
            hit_lat_reg  <= tcea_pkg::HIT_LATENCY_RST;
            miss_lat_reg <= tcea_pkg::MISS_LATENCY_RST;
            touched_reg  <= '0;
            ld_pend_reg  <= 1'b0;
        end
        else
        begin
            rf_reg       <= rf_next;
            pc_reg       <= pc_next;
            eq_reg       <= eq_next;
            instr_reg    <= instr_next;
            cycle_reg    <= cycle_next;
            hit_reg      <= hit_next;
            ldst_reg     <= ldst_next;
            touched_reg  <= touched_next;
            ld_pend_reg  <= ld_pend_next;
            // the user must write configuration only while idle; the block does not enforce this
            if (cfg_we)
            begin
                case (cfg_index)
                    tcea_pkg::CFG_HIT_LATENCY:  hit_lat_reg  <= cfg_data[7:0];
                    tcea_pkg::CFG_MISS_LATENCY: miss_lat_reg <= cfg_data[7:0];
                    default:                    ;
                endcase
            end
        end
    end

    // hold load destination and hit for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            ld_idx_reg <= dec.reg_a;
            ld_hit_reg <= hit;
        end
    end

    // local memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            local_mem[addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= local_mem[addr];
        end
    end

endmodule

`default_nettype wire

### sv/toy_cpu_execute_with_access_tracking_unit.sv
// Path: an accepted command word is registered in the command queue and executed, and its
// result is registered in the result buffer; a stall on the result port holds it there.
// Throughput: one command per cycle and one word retired per cycle unless stalled;
// a load writes its register the cycle after it executes, via the memory read port bypass.
// Reset clears registers, flag, totals and the touched map, sets PC to zero and the
// latencies to 2 and 45; the byte memory is not cleared, a byte reads as zero until touched.
`default_nettype none

module toy_cpu_execute_with_access_tracking_unit #(
    parameter int MEM_BYTES   = 256,
    parameter int NUM_REGS    = 6,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire tcea_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tcea_pkg::res_t      res,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);

    tcea_pkg::dec_t dec_in, dec_q;
    tcea_pkg::res_t exe_res;
    logic           dec_in_valid, dec_in_stall;
    logic           dec_q_valid, dec_q_stall;
    logic           exe_valid, exe_stall;
    logic           exe_fire;
    logic [$bits(tcea_pkg::dec_t)-1:0] dec_q_bits;
    logic [$bits(tcea_pkg::res_t)-1:0] res_bits;

    assign cfg_ready = 1'b1;
    assign dec_q     = tcea_pkg::dec_t'(dec_q_bits);
    assign res       = tcea_pkg::res_t'(res_bits);
    assign exe_fire  = dec_q_valid && !dec_q_stall;

    // classify incoming words
    tcea_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .dec_valid (dec_in_valid),
        .dec_stall (dec_in_stall),
        .dec       (dec_in)
    );

    // decouple front from execute
    tcea_fifo #(
        .WIDTH ($bits(tcea_pkg::dec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_in_valid),
        .push_stall (dec_in_stall),
        .push_data  (dec_in),
        .pop_valid  (dec_q_valid),
        .pop_stall  (dec_q_stall),
        .pop_data   (dec_q_bits)
    );

    // execute and keep machine state
    tcea_back #(
        .NUM_REGS  (NUM_REGS),
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dec_valid (dec_q_valid),
        .dec_stall (dec_q_stall),
        .dec       (dec_q),
        .res_valid (exe_valid),
        .res_stall (exe_stall),
        .res       (exe_res)
    );

    // register results toward the consumer
    tcea_fifo #(
        .WIDTH ($bits(tcea_pkg::res_t)),
        .DEPTH (tcea_pkg::RES_DEPTH)
    ) u_res_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (exe_valid),
        .push_stall (exe_stall),
        .push_data  (exe_res),
        .pop_valid  (res_valid),
        .pop_stall  (res_stall),
        .pop_data   (res_bits)
    );

    // an executed word is always buffered for output
    a_exe_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire |=> res_valid)
        else $error("executed word not offered on result port");

    // invalid opcodes charge nothing
    a_invalid_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.invalid_op) |-> (res.cycles_spent == 8'd0 && !res.access_hit))
        else $error("invalid opcode charged cycles or hit");

    // a hit is always counted
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.access_hit) |-> (res.hit_total != 32'd0 && res.ldst_total != 32'd0))
        else $error("hit reported without totals");

    // a valid instruction is always counted
    a_instr_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.invalid_op) |-> (res.instr_total != 32'd0))
        else $error("executed instruction not counted");

endmodule

`default_nettype wire
